/* rtl/core/galois_automorphism_index_map_defines.svh */
// Assertion macros used by the checker file of this block.
`ifndef GALOIS_AUTOMORPHISM_INDEX_MAP_DEFINES_SVH
`define GALOIS_AUTOMORPHISM_INDEX_MAP_DEFINES_SVH

// Implication to the next cycle, checked outside reset.
`define GAIM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("galois automorphism index map: assertion failed");

// Implication to the next cycle, checked during reset as well.
`define GAIM_ASSERT_NEXT_RST(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("galois automorphism index map: reset assertion failed");

`endif

/* rtl/core/gaim_pkg.sv */
package gaim_pkg;

   localparam int MAX_LOG_LEN = 16;
   localparam int IDX_W       = MAX_LOG_LEN;
   localparam int FACTOR_W    = MAX_LOG_LEN + 1;
   localparam int LOG_LEN_W   = 5;
   localparam int STEP_W      = 17;
   localparam int COEFF_W     = 64;
   localparam int CSR_DATA_W  = 17;
   localparam int CSR_INDEX_W = 2;

   localparam logic [LOG_LEN_W-1:0] LOG_LEN_RESET = LOG_LEN_W'(12);
   localparam logic [FACTOR_W-1:0]  GEN_THREE     = FACTOR_W'(3);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LOG_LEN       = 2'd0,
      CSR_MODE          = 2'd1,
      CSR_ROTATION_STEP = 2'd2
   } csr_index_type;

   typedef enum logic {
      MODE_ROTATE    = 1'b0,
      MODE_CONJUGATE = 1'b1
   } mode_type;

   typedef enum logic {
      POW_IDLE = 1'b0,
      POW_RUN  = 1'b1
   } pow_state_type;

   typedef struct packed {
      logic [LOG_LEN_W-1:0] log_len;
      mode_type             mode;
      logic [FACTOR_W-1:0]  factor;
   } map_cfg_type;

   function automatic logic [IDX_W-1:0] index_mask(input logic [LOG_LEN_W-1:0] nbits);
      index_mask = ~({IDX_W{1'b1}} << nbits);
   endfunction

   function automatic logic [IDX_W-1:0] reverse_bits(input logic [IDX_W-1:0]     v,
                                                     input logic [LOG_LEN_W-1:0] nbits);
      logic [IDX_W-1:0] r;
      r = '0;
      for (int k = 0; k < IDX_W; k++) begin
         r[IDX_W-1-k] = v[k];
      end
      reverse_bits = r >> (LOG_LEN_W'(IDX_W) - nbits);
   endfunction

endpackage

/* rtl/core/gaim_pow.sv */
module gaim_pow (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gaim_pkg::STEP_W-1:0]   step,
   output logic                          busy,
   output logic [gaim_pkg::FACTOR_W-1:0] factor
);
   import gaim_pkg::*;

   pow_state_type         state_ff, state_in;
   logic [FACTOR_W-1:0]   result_ff, result_in;
   logic [FACTOR_W-1:0]   base_ff, base_in;
   logic [STEP_W-1:0]     exp_ff, exp_in;
   logic [FACTOR_W-1:0]   rb_prod, bb_prod;

   assign rb_prod = result_ff * base_ff;
   assign bb_prod = base_ff * base_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         POW_IDLE: begin
            if (start) begin
               state_in = POW_RUN;
            end
         end
         POW_RUN: begin
            if (start) begin
               state_in = POW_RUN;
            end else if (exp_ff[STEP_W-1:1] == '0) begin
               state_in = POW_IDLE;
            end
         end
         default: state_in = POW_IDLE;
      endcase
   end

   always_comb begin
      busy = 1'b0;
      case (state_ff)
         POW_IDLE: busy = 1'b0;
         POW_RUN:  busy = 1'b1;
         default:  busy = 1'b0;
      endcase
   end

   always_comb begin
      result_in = result_ff;
      base_in   = base_ff;
      exp_in    = exp_ff;
      if (start) begin
         result_in = FACTOR_W'(1);
         base_in   = GEN_THREE;
         exp_in    = step;
      end else if (busy) begin
         if (exp_ff[0]) begin
            result_in = rb_prod;
         end
         base_in = bb_prod;
         exp_in  = exp_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= POW_IDLE;
         result_ff <= FACTOR_W'(1);
      end else begin
         state_ff  <= state_in;
         result_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      exp_ff  <= exp_in;
   end

   assign factor = result_ff;

endmodule

/* rtl/core/gaim_pipe.sv */
module gaim_pipe (
   input  logic                         clock,
   input  logic                         reset,
   input  gaim_pkg::map_cfg_type        cfg,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [gaim_pkg::IDX_W-1:0]   in_src_index,
   input  logic [gaim_pkg::COEFF_W-1:0] in_coeff,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [gaim_pkg::IDX_W-1:0]   out_dest_index,
   output logic [gaim_pkg::COEFF_W-1:0] out_coeff
);
   import gaim_pkg::*;

   logic                  s1_valid_ff;
   logic [FACTOR_W-1:0]   s1_root_ff, s1_root_in;
   logic [IDX_W-1:0]      s1_conj_ff, s1_conj_in;
   logic [COEFF_W-1:0]    s1_coeff_ff;
   logic                  s2_valid_ff;
   logic [FACTOR_W-1:0]   s2_moved_ff, s2_moved_in;
   logic [IDX_W-1:0]      s2_conj_ff;
   logic [COEFF_W-1:0]    s2_coeff_ff;
   logic                  s3_valid_ff;
   logic [IDX_W-1:0]      s3_dest_ff, s3_dest_in;
   logic [COEFF_W-1:0]    s3_coeff_ff;
   logic                  s1_ready, s2_ready, s3_ready;
   logic [IDX_W-1:0]      idx_mask;
   logic [FACTOR_W-1:0]   root_mask;
   logic [IDX_W-1:0]      src_masked;
   logic [FACTOR_W-1:0]   prod;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign idx_mask  = index_mask(cfg.log_len);
   assign root_mask = {idx_mask, 1'b1};

   // Stage one: bit-reverse the source index into an odd root index.
   assign src_masked = in_src_index & idx_mask;
   assign s1_root_in = {reverse_bits(src_masked, cfg.log_len), 1'b1};
   assign s1_conj_in = idx_mask & ~src_masked;

   // Stage two: multiply by the Galois factor modulo 2N.
   assign prod        = s1_root_ff * cfg.factor;
   assign s2_moved_in = prod & root_mask;

   // Stage three: map back to an index and reverse again, or take the conjugate index.
   assign s3_dest_in = (cfg.mode == MODE_CONJUGATE) ? s2_conj_ff :
                       reverse_bits(s2_moved_ff[FACTOR_W-1:1], cfg.log_len);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_root_ff  <= s1_root_in;
         s1_conj_ff  <= s1_conj_in;
         s1_coeff_ff <= in_coeff;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_moved_ff <= s2_moved_in;
         s2_conj_ff  <= s1_conj_ff;
         s2_coeff_ff <= s1_coeff_ff;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_dest_ff  <= s3_dest_in;
         s3_coeff_ff <= s2_coeff_ff;
      end
   end

   assign out_valid      = s3_valid_ff;
   assign out_dest_index = s3_dest_ff;
   assign out_coeff      = s3_coeff_ff;

endmodule

/* rtl/core/galois_automorphism_index_map.sv */
// Galois automorphism index map. Each item carries one NTT-domain coefficient and its
// source index; the block returns the coefficient with its destination index, either
// under the automorphism by three to the power rotation_step or under conjugation
// (N-1-src). The index path is a three-stage pipeline that accepts one item per clock
// unless the output stalls it or a new factor is being computed. A write to the
// rotation step register starts a square-and-multiply unit that works through the
// exponent bit by bit up to the highest set bit, and the input is held off
// (req_ready low) until the new factor is ready.
module galois_automorphism_index_map (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [gaim_pkg::IDX_W-1:0]       req_src_index,
   input  logic [gaim_pkg::COEFF_W-1:0]     req_coeff_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [gaim_pkg::IDX_W-1:0]       rsp_dest_index,
   output logic [gaim_pkg::COEFF_W-1:0]     rsp_coeff_out,
   input  logic                             csr_wr_en,
   input  logic [gaim_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gaim_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import gaim_pkg::*;

   logic [LOG_LEN_W-1:0] log_len_ff;
   mode_type             mode_ff;
   logic [LOG_LEN_W-1:0] log_len_eff;
   logic                 pow_start;
   logic                 pow_busy;
   logic [FACTOR_W-1:0]  pow_factor;
   map_cfg_type          cfg;
   logic                 pipe_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         log_len_ff <= LOG_LEN_RESET;
         mode_ff    <= MODE_ROTATE;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LOG_LEN: log_len_ff <= csr_wdata[LOG_LEN_W-1:0];
            CSR_MODE:    mode_ff    <= mode_type'(csr_wdata[0]);
            default:     log_len_ff <= log_len_ff;
         endcase
      end
   end

   assign pow_start = csr_wr_en && (csr_index == CSR_ROTATION_STEP);

   gaim_pow u_pow (
      .clock  (clock),
      .reset  (reset),
      .start  (pow_start),
      .step   (csr_wdata[STEP_W-1:0]),
      .busy   (pow_busy),
      .factor (pow_factor)
   );

   always_comb begin
      if (log_len_ff == '0) begin
         log_len_eff = LOG_LEN_W'(1);
      end else if (log_len_ff > LOG_LEN_W'(MAX_LOG_LEN)) begin
         log_len_eff = LOG_LEN_W'(MAX_LOG_LEN);
      end else begin
         log_len_eff = log_len_ff;
      end
   end

   assign cfg.log_len = log_len_eff;
   assign cfg.mode    = mode_ff;
   assign cfg.factor  = pow_factor;

   gaim_pipe u_pipe (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .in_valid       (req_valid && !pow_busy),
      .in_ready       (pipe_ready),
      .in_src_index   (req_src_index),
      .in_coeff       (req_coeff_in),
      .out_valid      (rsp_valid),
      .out_ready      (rsp_ready),
      .out_dest_index (rsp_dest_index),
      .out_coeff      (rsp_coeff_out)
   );

   assign req_ready = pipe_ready && !pow_busy;

endmodule

/* rtl/core/gaim_checker.sv */
`include "galois_automorphism_index_map_defines.svh"

module gaim_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [gaim_pkg::IDX_W-1:0]       rsp_dest_index,
   input logic [gaim_pkg::COEFF_W-1:0]     rsp_coeff_out,
   input logic                             csr_wr_en,
   input logic [gaim_pkg::CSR_INDEX_W-1:0] csr_index
);
   import gaim_pkg::*;

   // A stalled result item keeps its payload.
   `GAIM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_dest_index) && $stable(rsp_coeff_out))

   // A new rotation step holds off input while the factor is recomputed.
   `GAIM_ASSERT_NEXT(a_step_blocks_req, csr_wr_en && (csr_index == CSR_ROTATION_STEP), !req_ready)

   // Reset empties the pipeline.
   `GAIM_ASSERT_NEXT_RST(a_reset_empty, reset, !rsp_valid)

endmodule

bind galois_automorphism_index_map gaim_checker u_gaim_checker (.*);
